/* design/pmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types, character codes and result patterns for the movetext tokenizer.
// ----------------------------------------------------------------------------
package pmt_pkg;

   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_LBRACE = 8'h7B;
   localparam logic [7:0] CHR_RBRACE = 8'h7D;
   localparam logic [7:0] CHR_LPAREN = 8'h28;
   localparam logic [7:0] CHR_RPAREN = 8'h29;
   localparam logic [7:0] CHR_BANG   = 8'h21;
   localparam logic [7:0] CHR_QUERY  = 8'h3F;
   localparam logic [7:0] CHR_DOT    = 8'h2E;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;

   // game result patterns
   localparam int          NUM_PATTERNS = 4;
   localparam logic [1:0]  PAT_WHITE    = 2'd0;   // 1-0
   localparam logic [1:0]  PAT_BLACK    = 2'd1;   // 0-1
   localparam logic [1:0]  PAT_DRAW     = 2'd2;   // 1/2-1/2
   localparam logic [1:0]  PAT_OPEN     = 2'd3;   // *

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic has_token;
      logic head_ovf;
   } queue_status_type;

   function automatic logic [2:0] pattern_len(input logic [1:0] pat);
      logic [2:0] len;
      case (pat)
         PAT_WHITE: len = 3'd3;
         PAT_BLACK: len = 3'd3;
         PAT_DRAW:  len = 3'd7;
         PAT_OPEN:  len = 3'd1;
         default:   len = 3'd1;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] pattern_char(input logic [1:0] pat, input logic [2:0] pos);
      logic [7:0] chr;
      chr = 8'h00;
      case (pat)
         PAT_WHITE: begin
            case (pos)
               3'd0:    chr = "1";
               3'd1:    chr = "-";
               3'd2:    chr = "0";
               default: chr = 8'h00;
            endcase
         end
         PAT_BLACK: begin
            case (pos)
               3'd0:    chr = "0";
               3'd1:    chr = "-";
               3'd2:    chr = "1";
               default: chr = 8'h00;
            endcase
         end
         PAT_DRAW: begin
            case (pos)
               3'd0:    chr = "1";
               3'd1:    chr = "/";
               3'd2:    chr = "2";
               3'd3:    chr = "-";
               3'd4:    chr = "1";
               3'd5:    chr = "/";
               3'd6:    chr = "2";
               default: chr = 8'h00;
            endcase
         end
         PAT_OPEN: begin
            case (pos)
               3'd0:    chr = "*";
               default: chr = 8'h00;
            endcase
         end
         default: chr = 8'h00;
      endcase
      return chr;
   endfunction

endpackage

/* design/pmt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_front
// Byte intake: comment and variation tracking, token building and classification.
// ----------------------------------------------------------------------------
module pmt_front #(
   parameter int MAX_TOKEN = 16,
   parameter int IDX_W     = 4,
   parameter int CNT_W     = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] text_byte
   input  logic                        req_tlast,   // end_of_text
   input  pmt_pkg::queue_status_type   qstat,
   output logic                        wr_en,
   output logic [IDX_W-1:0]            wr_idx,
   output logic [7:0]                  wr_data,
   output logic                        push,
   output logic [CNT_W-1:0]            push_kept,
   output logic                        push_ovf
);

   localparam logic [1:0] CLS_EMPTY  = 2'd0;
   localparam logic [1:0] CLS_DIGITS = 2'd1;
   localparam logic [1:0] CLS_DOTS   = 2'd2;
   localparam logic [1:0] CLS_OTHER  = 2'd3;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TOKEN);

   logic                    comment_ff, comment_in;
   logic [7:0]              nest_ff, nest_in, nest_flush;
   logic [CNT_W-1:0]        count_ff, count_a;
   logic [CNT_W-1:0]        kept_ff, kept_a;
   logic                    ovf_ff, ovf_a;
   logic [1:0]              class_ff, class_a;
   logic [pmt_pkg::NUM_PATTERNS-1:0] match_ff, match_a, equal;
   logic                    dollar_ff, dollar_a;
   logic                    accept, delim, append, flush, keep;
   logic                    is_space, is_suffix, is_digit;
   logic [7:0]              b;

   assign b          = req_tdata;
   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign is_space   = (b == pmt_pkg::CHR_SPACE) ||
                       (b >= pmt_pkg::CHR_TAB && b <= pmt_pkg::CHR_CR);
   assign is_suffix  = (b == pmt_pkg::CHR_BANG) || (b == pmt_pkg::CHR_QUERY);
   assign is_digit   = (b >= pmt_pkg::CHR_ZERO) && (b <= pmt_pkg::CHR_NINE);

   always_comb begin
      comment_in = comment_ff;
      nest_in    = nest_ff;
      delim      = 1'b0;
      append     = 1'b0;
      if (comment_ff) begin
         if (b == pmt_pkg::CHR_RBRACE) begin
            comment_in = 1'b0;
         end
      end else if (b == pmt_pkg::CHR_LBRACE) begin
         delim      = 1'b1;
         comment_in = 1'b1;
      end else if (b == pmt_pkg::CHR_LPAREN) begin
         delim = 1'b1;
         if (nest_ff != 8'hFF) begin
            nest_in = nest_ff + 8'd1;
         end
      end else if (b == pmt_pkg::CHR_RPAREN) begin
         delim = 1'b1;
         if (nest_ff != 8'h00) begin
            nest_in = nest_ff - 8'd1;
         end
      end else if (is_space) begin
         delim = 1'b1;
      end else if (nest_ff == 8'h00) begin
         append = 1'b1;
      end
      // the end-of-text flush sees the depth before this byte
      nest_flush = delim ? nest_ff : nest_in;
   end

   // token state after this byte is appended
   always_comb begin
      count_a  = count_ff;
      kept_a   = kept_ff;
      ovf_a    = ovf_ff;
      class_a  = class_ff;
      match_a  = match_ff;
      dollar_a = dollar_ff;
      wr_en    = 1'b0;
      if (append) begin
         case (class_ff)
            CLS_EMPTY:  class_a = is_digit ? CLS_DIGITS : CLS_OTHER;
            CLS_DIGITS: class_a = is_digit ? CLS_DIGITS :
                                  ((b == pmt_pkg::CHR_DOT) ? CLS_DOTS : CLS_OTHER);
            CLS_DOTS:   class_a = (b == pmt_pkg::CHR_DOT) ? CLS_DOTS : CLS_OTHER;
            default:    class_a = CLS_OTHER;
         endcase
         for (int p = 0; p < pmt_pkg::NUM_PATTERNS; p++) begin
            match_a[p] = match_ff[p] &&
                         (count_ff < CNT_W'(pmt_pkg::pattern_len(2'(p)))) &&
                         (b == pmt_pkg::pattern_char(2'(p), count_ff[2:0]));
         end
         if (count_ff == '0) begin
            dollar_a = (b == pmt_pkg::CHR_DOLLAR);
         end
         if (count_ff < MAX_CNT) begin
            wr_en   = accept;
            count_a = count_ff + CNT_W'(1);
            if (!is_suffix) begin
               kept_a = count_ff + CNT_W'(1);
            end
         end else if (!is_suffix) begin
            ovf_a  = 1'b1;
            kept_a = MAX_CNT;
         end
      end
   end

   always_comb begin
      for (int p = 0; p < pmt_pkg::NUM_PATTERNS; p++) begin
         equal[p] = match_a[p] && (count_a == CNT_W'(pmt_pkg::pattern_len(2'(p))));
      end
   end

   assign flush = delim || req_tlast;
   assign keep  = (count_a != '0) && (nest_flush == 8'h00) &&
                  (class_a != CLS_DIGITS) && (class_a != CLS_DOTS) &&
                  !dollar_a && (equal == '0) && (kept_a != '0);

   assign wr_idx    = count_ff[IDX_W-1:0];
   assign wr_data   = b;
   assign push      = accept && flush && keep;
   assign push_kept = kept_a;
   assign push_ovf  = ovf_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff <= 1'b0;
         nest_ff    <= 8'h00;
         count_ff   <= '0;
         kept_ff    <= '0;
         ovf_ff     <= 1'b0;
         class_ff   <= CLS_EMPTY;
         match_ff   <= '1;
         dollar_ff  <= 1'b0;
      end else if (accept) begin
         comment_ff <= req_tlast ? 1'b0 : comment_in;
         nest_ff    <= req_tlast ? 8'h00 : nest_in;
         if (flush) begin
            count_ff  <= '0;
            kept_ff   <= '0;
            ovf_ff    <= 1'b0;
            class_ff  <= CLS_EMPTY;
            match_ff  <= '1;
            dollar_ff <= 1'b0;
         end else begin
            count_ff  <= count_a;
            kept_ff   <= kept_a;
            ovf_ff    <= ovf_a;
            class_ff  <= class_a;
            match_ff  <= match_a;
            dollar_ff <= dollar_a;
         end
      end
   end

endmodule

/* design/pmt_token_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_token_queue
// Two-token buffer: character memory with one bank per token plus descriptors.
// ----------------------------------------------------------------------------
module pmt_token_queue #(
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [7:0]                  wr_data,
   input  logic                        push,
   input  logic [CNT_W-1:0]            push_kept,
   input  logic                        push_ovf,
   input  logic                        pop,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_idx,
   output logic [7:0]                  rd_data,
   output logic [CNT_W-1:0]            head_kept,
   output pmt_pkg::queue_status_type   qstat
);

   localparam int MEM_DEPTH = 2 * (1 << IDX_W);

   logic [7:0]       mem [MEM_DEPTH];
   logic [7:0]       rd_data_ff;
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0] kept_ff [2];
   logic             ovf_ff  [2];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_ptr_ff, wr_idx}] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[{rd_ptr_ff, rd_idx}];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kept_ff[wr_ptr_ff] <= push_kept;
         ovf_ff[wr_ptr_ff]  <= push_ovf;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

   assign rd_data         = rd_data_ff;
   assign head_kept       = kept_ff[rd_ptr_ff];
   assign qstat.full      = (fill_ff == 2'd2);
   assign qstat.has_token = (fill_ff != 2'd0);
   assign qstat.head_ovf  = ovf_ff[rd_ptr_ff];

endmodule

/* design/pmt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_back
// Token emitter: head token to output register, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module pmt_back #(
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pmt_pkg::queue_status_type   qstat,
   input  logic [CNT_W-1:0]            head_kept,
   input  logic [7:0]                  rd_data,
   output logic                        rd_en,
   output logic [IDX_W-1:0]            rd_idx,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] token_byte
   output logic                        rsp_tlast,   // token_end
   output logic                        rsp_tuser    // token_truncated
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic             end_meta_ff, trunc_meta_ff;
   logic             valid_ff, valid_in;
   logic [7:0]       data_ff;
   logic             last_ff, trunc_ff;
   logic             slot_free, issue, last_chr, load;

   assign slot_free = !valid_ff || rsp_tready;
   // a new read goes out only if the previous one leaves the read register now
   assign issue     = qstat.has_token && (!pend_ff || slot_free);
   assign last_chr  = (CNT_W'(idx_ff) + CNT_W'(1)) == head_kept;
   assign load      = pend_ff && slot_free;

   assign rd_en  = issue;
   assign rd_idx = idx_ff;
   assign pop    = issue && last_chr;

   always_comb begin
      idx_in = idx_ff;
      if (issue) begin
         idx_in = last_chr ? '0 : idx_ff + IDX_W'(1);
      end
      pend_in  = issue || (pend_ff && !slot_free);
      valid_in = load || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         end_meta_ff   <= last_chr;
         trunc_meta_ff <= qstat.head_ovf;
      end
      if (load) begin
         data_ff  <= rd_data;
         last_ff  <= end_meta_ff;
         trunc_ff <= trunc_meta_ff;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = trunc_ff;

endmodule

/* design/pgn_movetext_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgn_movetext_tokenizer_core
// Chess movetext tokenizer: skips comments and variations, emits move tokens.
// ----------------------------------------------------------------------------
// intake: one byte per cycle; stalls only while two finished tokens wait to drain
// drain: a queued token's first character passes the read and output registers
// output: one character per cycle unless stalled, from the buffer's single read port
// reset: synchronous, clears depth, comment, token and queue state; no clearing pass
module pgn_movetext_tokenizer_core #(
   parameter int MAX_TOKEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] token_byte
   output logic        rsp_tlast,   // token_end
   output logic        rsp_tuser    // token_truncated
);

   localparam int IDX_W = $clog2(MAX_TOKEN);
   localparam int CNT_W = $clog2(MAX_TOKEN + 1);

   pmt_pkg::queue_status_type qstat;
   logic             wr_en, push, push_ovf, pop, rd_en;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   logic [7:0]       wr_data, rd_data;
   logic [CNT_W-1:0] push_kept, head_kept;

   pmt_front #(
      .MAX_TOKEN (MAX_TOKEN),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .qstat      (qstat),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .wr_data    (wr_data),
      .push       (push),
      .push_kept  (push_kept),
      .push_ovf   (push_ovf)
   );

   pmt_token_queue #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .push      (push),
      .push_kept (push_kept),
      .push_ovf  (push_ovf),
      .pop       (pop),
      .rd_en     (rd_en),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .head_kept (head_kept),
      .qstat     (qstat)
   );

   pmt_back #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_kept  (head_kept),
      .rd_data    (rd_data),
      .rd_en      (rd_en),
      .rd_idx     (rd_idx),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
